/* src/deque_with_search_macros.svh */
// Assertion helpers used by the top-level deque module.
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication.
`define DWS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dws_pkg.sv */
package dws_pkg;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned OCNT_W = 5;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic [CMD_W-1:0] CMD_PUSH_TAIL  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_HEAD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic pop_load;
        logic srch_step;
        logic out_load;
    } dws_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             srch_done;
        logic             out_free;
    } dws_stat_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [POS_W-1:0]  found_position;
        logic [VAL_W-1:0]  front_value;
        logic [VAL_W-1:0]  back_value;
        logic [OCNT_W-1:0] count;
        logic              is_empty;
    } dws_res_t;

    // ring slot arithmetic, both operands below DEPTH
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W+1)'(DEPTH))
        begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == '0)
        begin
            r = IDX_W'(DEPTH - 1);
        end
        else
        begin
            r = a - 1'b1;
        end
        return r;
    endfunction

endpackage

/* src/dws_ctrl.sv */
module dws_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  dws_pkg::dws_stat_t stat,
    output dws_pkg::dws_ctrl_t ctrl,
    output logic               s_tready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SRCH,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        ctrl.accept    = s_tvalid && ready_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.accept)
                begin
                    priority if (stat.in_cmd == dws_pkg::CMD_POP_HEAD)
                        state_next = S_POP;
                    else if (stat.in_cmd == dws_pkg::CMD_SEARCH)
                        state_next = S_SRCH;
                    else
                        state_next = S_RESULT;
                end
            end
            S_POP:
            begin
                ctrl.pop_load = 1'b1;
                state_next    = S_RESULT;
            end
            S_SRCH:
            begin
                ctrl.srch_step = 1'b1;
                if (stat.srch_done)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

/* src/dws_dp.sv */
module dws_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dws_pkg::dws_ctrl_t              ctrl,
    input  logic [dws_pkg::CMD_W-1:0]       in_cmd,
    input  logic [dws_pkg::VAL_W-1:0]       in_value,
    input  logic                            m_tready,
    output dws_pkg::dws_stat_t              stat,
    output dws_pkg::dws_res_t               res,
    output logic                            m_tvalid
);

    localparam int unsigned IDX_W = dws_pkg::IDX_W;
    localparam int unsigned CNT_W = dws_pkg::CNT_W;
    localparam int unsigned DW    = dws_pkg::DATA_WIDTH;

    logic [DW-1:0] mem [dws_pkg::DEPTH];

    // control state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_tvalid_reg;

    // payload
    logic [DW-1:0]             value_reg;
    logic [DW-1:0]             front_val_reg, front_val_next;
    logic [DW-1:0]             back_val_reg, back_val_next;
    logic [dws_pkg::STAT_W-1:0] status_reg, status_next;
    logic                      pop_ok_reg, pop_ok_next;
    logic                      found_reg;
    logic [IDX_W-1:0]          pos_reg;
    logic [CNT_W-1:0]          rd_idx_reg;
    logic [IDX_W-1:0]          cmp_idx_reg;
    logic                      cmp_valid_reg;
    logic [DW-1:0]             rd_data_reg;
    dws_pkg::dws_res_t         res_reg;

    logic [DW-1:0]    in_data;
    logic             full, empty, hit, issue;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;

    assign in_data = DW'(in_value);
    assign full    = (count_reg == dws_pkg::DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign hit     = cmp_valid_reg && (rd_data_reg == value_reg);
    assign issue   = ctrl.srch_step && (rd_idx_reg < count_reg);

    // pop fetches the new front; search walks from the front
    assign rd_addr = ctrl.accept ? dws_pkg::slot_add(front_reg, IDX_W'(1))
                                 : dws_pkg::slot_add(front_reg, rd_idx_reg[IDX_W-1:0]);

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        front_val_next = front_val_reg;
        back_val_next  = back_val_reg;
        status_next    = dws_pkg::ST_OK;
        pop_ok_next    = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = dws_pkg::slot_add(front_reg, count_reg[IDX_W-1:0]);
        unique case (in_cmd)
            dws_pkg::CMD_PUSH_TAIL:
            begin
                if (full)
                begin
                    status_next = dws_pkg::ST_FULL;
                end
                else
                begin
                    wr_en         = 1'b1;
                    count_next    = count_reg + 1'b1;
                    back_val_next = in_data;
                    if (empty)
                        front_val_next = in_data;
                end
            end
            dws_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = dws_pkg::ST_FULL;
                end
                else
                begin
                    wr_en          = 1'b1;
                    front_next     = dws_pkg::slot_dec(front_reg);
                    wr_addr        = front_next;
                    count_next     = count_reg + 1'b1;
                    front_val_next = in_data;
                    if (empty)
                        back_val_next = in_data;
                end
            end
            dws_pkg::CMD_POP_HEAD:
            begin
                if (empty)
                begin
                    status_next = dws_pkg::ST_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (count_next == '0)
                        front_next = '0;
                    else
                        front_next = dws_pkg::slot_add(front_reg, IDX_W'(1));
                end
            end
            dws_pkg::CMD_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
                // search and unused codes leave the ring alone
            end
        endcase
    end

    // ring store
    always_ff @(posedge clk)
    begin
        if (ctrl.accept && wr_en)
            mem[wr_addr] <= in_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (ctrl.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            value_reg     <= in_data;
            front_val_reg <= front_val_next;
            back_val_reg  <= back_val_next;
            status_reg    <= status_next;
            pop_ok_reg    <= pop_ok_next;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.pop_load && pop_ok_reg)
                front_val_reg <= rd_data_reg;
            if (ctrl.srch_step)
            begin
                if (hit && !found_reg)
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= cmp_idx_reg;
                end
                cmp_valid_reg <= issue;
                cmp_idx_reg   <= rd_idx_reg[IDX_W-1:0];
                if (issue)
                    rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
        if (ctrl.out_load)
        begin
            res_reg.status         <= status_reg;
            res_reg.found          <= found_reg;
            res_reg.found_position <= dws_pkg::POS_W'(pos_reg);
            res_reg.front_value    <= empty ? '0 : dws_pkg::VAL_W'(front_val_reg);
            res_reg.back_value     <= empty ? '0 : dws_pkg::VAL_W'(back_val_reg);
            res_reg.count          <= dws_pkg::OCNT_W'(count_reg);
            res_reg.is_empty       <= empty;
        end
    end

    assign stat.in_cmd    = in_cmd;
    assign stat.srch_done = hit || (rd_idx_reg == count_reg);
    assign stat.out_free  = !m_tvalid_reg || m_tready;
    assign res            = res_reg;
    assign m_tvalid       = m_tvalid_reg;

endmodule

/* src/deque_with_search.sv */
// Channel   Dir  Width  Contents
// s_*       in   40     command transfers: {value, command}
// m_*       out  80     result transfers: status, search outcome, front/back, count
//
// Push, push-front, clear and unused codes go from accept straight to the result
// step; pop adds a fetch step (one ring-store read for the new front). Search walks
// the live entries from the front: the single read port of the ring store reads one
// entry per cycle, pipelined against the compare, and a match ends the walk early.
// rst_n clears the ring pointers and the output valid; the store itself is left
// as is. A held result on m_* does not block the next accept; a command waits in
// the result step until m_* frees up.
`include "deque_with_search_macros.svh"

module deque_with_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] command, [34:3] value, [39:35] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [2] found, [6:3] found_position, [38:7] front_value,
    // [70:39] back_value, [75:71] count, [76] is_empty, [79:77] zero
    output logic [79:0] m_tdata
);

    dws_pkg::dws_ctrl_t ctrl;
    dws_pkg::dws_stat_t stat;
    dws_pkg::dws_res_t  res;

    logic [dws_pkg::CMD_W-1:0] in_cmd;
    logic [dws_pkg::VAL_W-1:0] in_value;

    assign in_cmd   = s_tdata[2:0];
    assign in_value = s_tdata[34:3];

    // sequencing: accept, pop fetch, search walk, result
    dws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .ctrl     (ctrl),
        .s_tready (s_tready)
    );

    // ring store, pointers, search compare and output register
    dws_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_cmd   (in_cmd),
        .in_value (in_value),
        .m_tready (m_tready),
        .stat     (stat),
        .res      (res),
        .m_tvalid (m_tvalid)
    );

    assign m_tdata = {3'b000, res.is_empty, res.count, res.back_value, res.front_value,
                      res.found_position, res.found, res.status};

    // one command in flight: an accept closes the input until its result is loaded for m_*
    `DWS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second accept in flight")

    `DWS_ASSERT_IMPL(a_empty_flag, m_tvalid, res.is_empty == (res.count == '0), "is_empty mismatch")

    `DWS_ASSERT_IMPL(a_count_bound, m_tvalid, res.count <= dws_pkg::OCNT_W'(dws_pkg::DEPTH),
                     "count above depth")

    `DWS_ASSERT_IMPL(a_found_ok, m_tvalid && res.found, res.status == dws_pkg::ST_OK,
                     "found with bad status")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

// Deque-with-search block-level bench.
// A command stream goes in on s_*, one result per command comes back on m_*.
// The bench keeps its own ring model of the deque, predicts each result when
// its command transfer happens, and compares every result field against the
// oldest prediction. Both handshake sides are randomly throttled in phases.

module tb_top;

    localparam int unsigned CLK_HALF      = 6;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned SETTLE_CYCLES = 40;    // quiet stretch to catch late results
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned HOLD_CYCLES   = 300;   // long receiver stall
    localparam int unsigned RUN_LIMIT_NS  = 5_000_000;

    // codes with no operation behind them
    localparam logic [dws_pkg::CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [dws_pkg::CMD_W-1:0] CMD_RSVD_MID = 3'd6;
    localparam logic [dws_pkg::CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] command, [34:3] value, [39:35] zero
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [1:0] status, [2] found, [6:3] found_position, [38:7] front_value,
    // [70:39] back_value, [75:71] count, [76] is_empty, [79:77] zero
    logic [79:0] m_tdata;

    // throttling knobs, percent of cycles spent idle
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // receiver hold-off: request from a test, countdown in the receiver process
    int unsigned hold_request  = 0;
    int unsigned hold_left     = 0;

    int unsigned error_count   = 0;
    int unsigned result_index  = 0;

    // predicted results, oldest first
    dws_pkg::dws_res_t pending_results[$];

    // deque model: ring store, front slot, number of live entries
    logic [dws_pkg::DATA_WIDTH-1:0] ring_model[dws_pkg::DEPTH];
    logic [dws_pkg::IDX_W-1:0]      ring_head = '0;
    int unsigned                    ring_live = 0;

    deque_with_search DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Apply one command to the ring model and return the result it produces.
    // Only live slots are ever read, so never-written slots don't matter.
    function automatic dws_pkg::dws_res_t predict_deque_result(
        input logic [dws_pkg::CMD_W-1:0] cmd,
        input logic [dws_pkg::VAL_W-1:0] value);
        dws_pkg::dws_res_t              r;
        logic [dws_pkg::DATA_WIDTH-1:0] v;
        int unsigned                    i;
        r = '0;
        v = value[dws_pkg::DATA_WIDTH-1:0];
        case (cmd)
            dws_pkg::CMD_PUSH_TAIL:
            begin
                if (ring_live >= dws_pkg::DEPTH)
                    r.status = dws_pkg::ST_FULL;
                else
                begin
                    ring_model[(ring_head + ring_live) % dws_pkg::DEPTH] = v;
                    ring_live++;
                end
            end
            dws_pkg::CMD_PUSH_FRONT:
            begin
                if (ring_live >= dws_pkg::DEPTH)
                    r.status = dws_pkg::ST_FULL;
                else
                begin
                    ring_head = dws_pkg::IDX_W'((ring_head + dws_pkg::DEPTH - 1)
                                                % dws_pkg::DEPTH);
                    ring_model[ring_head] = v;
                    ring_live++;
                end
            end
            dws_pkg::CMD_POP_HEAD:
            begin
                if (ring_live == 0)
                    r.status = dws_pkg::ST_EMPTY;
                else
                begin
                    ring_head = dws_pkg::IDX_W'((ring_head + 1) % dws_pkg::DEPTH);
                    ring_live--;
                    // front slot snaps back to zero once the deque drains
                    if (ring_live == 0)
                        ring_head = '0;
                end
            end
            dws_pkg::CMD_SEARCH:
            begin
                // first match from the front wins
                for (i = 0; i < ring_live; i++)
                begin
                    if (!r.found && ring_model[(ring_head + i) % dws_pkg::DEPTH] == v)
                    begin
                        r.found          = 1'b1;
                        r.found_position = dws_pkg::POS_W'(i);
                    end
                end
            end
            dws_pkg::CMD_CLEAR:
            begin
                ring_head = '0;
                ring_live = 0;
            end
            default:
            begin
                // unused codes: no change, status ok
            end
        endcase
        if (ring_live != 0)
        begin
            r.front_value = dws_pkg::VAL_W'(ring_model[ring_head]);
            r.back_value  = dws_pkg::VAL_W'(
                ring_model[(ring_head + ring_live - 1) % dws_pkg::DEPTH]);
        end
        r.count    = dws_pkg::OCNT_W'(ring_live);
        r.is_empty = (ring_live == 0);
        return r;
    endfunction

    task automatic check_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d: %s expected %h, got %h",
                         result_index, field_name, want, got);
        end
    endtask

    // Unpack one result transfer and compare it with the oldest prediction.
    task automatic check_result(input logic [79:0] beat);
        dws_pkg::dws_res_t got;
        dws_pkg::dws_res_t want;
        got.status         = beat[1:0];
        got.found          = beat[2];
        got.found_position = beat[6:3];
        got.front_value    = beat[38:7];
        got.back_value     = beat[70:39];
        got.count          = beat[75:71];
        got.is_empty       = beat[76];
        if (pending_results.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result with nothing outstanding: %h", beat);
        end
        else
        begin
            want = pending_results[0];
            pending_results.delete(0);
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("found", 32'(want.found), 32'(got.found));
            check_field("found_position", 32'(want.found_position),
                        32'(got.found_position));
            check_field("front_value", want.front_value, got.front_value);
            check_field("back_value", want.back_value, got.back_value);
            check_field("count", 32'(want.count), 32'(got.count));
            check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            if (beat[79:77] !== 3'b000)
                check_field("pad bits", 32'd0, 32'(beat[79:77]));
        end
        result_index++;
    endtask

    // Result side: check each transfer, then pick tready for the next edge.
    // A pending hold request turns into a countdown of stalled cycles.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata);
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Offer one command until it is taken; predict its result on the transfer.
    // Called at a rising edge. tvalid is left high after the transfer so
    // back-to-back commands need no extra assignment in the same step.
    task automatic send_command(input logic [dws_pkg::CMD_W-1:0] cmd,
                                input logic [dws_pkg::VAL_W-1:0] value);
        dws_pkg::dws_res_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        predicted       = predict_deque_result(cmd, value);
        pending_results = {pending_results, predicted};
    endtask

    // Sender stops and waits for every outstanding result.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Mix of extremes, a small pool (duplicates for first-match), and full random.
    function automatic logic [dws_pkg::VAL_W-1:0] random_value();
        logic [dws_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h8000_0000;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            1:       v = dws_pkg::VAL_W'($urandom_range(0, 7));
            default: v = dws_pkg::VAL_W'($urandom);
        endcase
        return v;
    endfunction

    // Searches mostly target a live entry so hits land at every position.
    function automatic logic [dws_pkg::VAL_W-1:0] search_value();
        logic [dws_pkg::VAL_W-1:0] v;
        if (ring_live != 0 && $urandom_range(0, 3) != 0)
            v = dws_pkg::VAL_W'(ring_model[(ring_head + $urandom_range(0, ring_live - 1))
                                           % dws_pkg::DEPTH]);
        else
            v = random_value();
        return v;
    endfunction

    function automatic logic [dws_pkg::CMD_W-1:0] random_command(
        input int unsigned push_pct);
        logic [dws_pkg::CMD_W-1:0] cmd;
        int unsigned               roll;
        if ($urandom_range(0, 99) < push_pct)
            cmd = $urandom_range(0, 1) ? dws_pkg::CMD_PUSH_FRONT : dws_pkg::CMD_PUSH_TAIL;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                cmd = dws_pkg::CMD_POP_HEAD;
            else if (roll < 92)
                cmd = dws_pkg::CMD_SEARCH;
            else if (roll < 96)
                cmd = dws_pkg::CMD_CLEAR;
            else
                cmd = dws_pkg::CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        end
        return cmd;
    endfunction

    // Corner cases: empty pop/search, extremes, fill to full, full pushes,
    // match at the last position, unused codes, clear.
    task automatic test_directed();
        int k;
        send_command(dws_pkg::CMD_POP_HEAD, 32'h0000_0000);
        send_command(dws_pkg::CMD_SEARCH, 32'h0000_0000);
        send_command(CMD_RSVD_LO, 32'hFFFF_FFFF);
        send_command(dws_pkg::CMD_PUSH_TAIL, 32'h7FFF_FFFF);
        send_command(dws_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
        send_command(dws_pkg::CMD_SEARCH, 32'h8000_0000);
        send_command(dws_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
        send_command(dws_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
        send_command(CMD_RSVD_MID, 32'h5555_5555);
        // fill the remaining 14 slots, alternating ends; all-ones lands at the back
        for (k = 0; k < 14; k++)
            send_command(k[0] ? dws_pkg::CMD_PUSH_TAIL : dws_pkg::CMD_PUSH_FRONT,
                         (k == 13) ? 32'hFFFF_FFFF :
                         (k == 5)  ? 32'h7FFF_FFFF : dws_pkg::VAL_W'(k));
        send_command(dws_pkg::CMD_PUSH_TAIL, 32'h1234_5678);
        send_command(dws_pkg::CMD_PUSH_FRONT, 32'hEDCB_A987);
        send_command(dws_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
        send_command(dws_pkg::CMD_POP_HEAD, 32'hAAAA_AAAA);
        send_command(CMD_RSVD_HI, 32'h0000_0000);
        send_command(dws_pkg::CMD_CLEAR, 32'h0000_0000);
    endtask

    // Random traffic; push bias re-drawn every 40 commands so the deque
    // swings between empty and full.
    task automatic test_random_traffic(input int unsigned items);
        int unsigned               n;
        int unsigned               push_pct;
        logic [dws_pkg::CMD_W-1:0] cmd;
        push_pct = 50;
        for (n = 0; n < items; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 75;
                endcase
            end
            cmd = random_command(push_pct);
            send_command(cmd, (cmd == dws_pkg::CMD_SEARCH) ? search_value() : random_value());
        end
    endtask

    // Receiver stalls for a long stretch while commands keep coming, so the
    // block backs up and drops s_tready.
    task automatic test_receiver_hold();
        int unsigned               n;
        logic [dws_pkg::CMD_W-1:0] cmd;
        hold_request = HOLD_CYCLES;
        for (n = 0; n < 20; n++)
        begin
            cmd = random_command(75);
            send_command(cmd, (cmd == dws_pkg::CMD_SEARCH) ? search_value() : random_value());
        end
        wait_for_drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 75;
        test_directed();
        test_random_traffic(300);
        wait_for_drain();

        test_receiver_hold();

        send_idle_pct = 75;
        recv_idle_pct = 30;
        test_random_traffic(300);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300);
        wait_for_drain();

        // catch any stray late results
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #RUN_LIMIT_NS;
        $display("Test completed with failures");
        $finish;
    end

endmodule
